/* sv/sht_pkg.sv */
// Package: phase codes, command codes, reset values and queue entry types for the SHT1x master.
package sht_pkg;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START, PH_CB0, PH_CB1, PH_CB2, PH_CA0, PH_CA1,
        PH_WB0, PH_WB1, PH_WB2, PH_WA0, PH_WA1, PH_WAIT, PH_MDLY,
        PH_DB0, PH_DB1, PH_DA0, PH_DA1, PH_KB0, PH_KB1, PH_KE0, PH_KE1
    } phase_t;

    typedef enum logic [1:0] {
        CFG_PHASE_TICKS   = 2'd0,
        CFG_TIMEOUT_TICKS = 2'd1,
        CFG_TEMP_OFFSET   = 2'd2
    } cfg_idx_t;

    localparam logic [7:0] CMD_MEAS_TEMP    = 8'h03;
    localparam logic [7:0] CMD_MEAS_HUMI    = 8'h05;
    localparam logic [7:0] CMD_WRITE_STATUS = 8'h06;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h07;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
    localparam logic [23:0] TIMEOUT_RST     = 24'd500000;
    localparam logic [13:0] TEMP_OFFSET_RST = 14'h3056;   // -4010

    localparam logic [6:0] START_SCL = 7'b0110110;   // bit i = step i
    localparam logic [6:0] START_SDA = 7'b1100011;

    localparam int signed HUM_BIAS = -4194304;
    localparam int        HUM_LIN  = 42467;
    localparam int        HUM_QUAD = 3006;

    // one tick as it travels from front to back
    typedef struct packed {
        logic       action;
        logic [7:0] command_code;
        logic [7:0] status_data;
        logic       sda_in;
    } tick_t;

    // one finished tick before the held values are attached
    typedef struct packed {
        logic scl;
        logic rel;
        logic busy;
        logic done;
        logic nack;
        logic tmo;
    } pins_t;

    // conversion request from the bus engine
    typedef struct packed {
        logic        go;
        logic [7:0]  cmd;
        logic [15:0] raw;
    } conv_t;

endpackage

/* sv/sht_front.sv */
// Front part: tick acceptance into a two-entry queue.
module sht_front import sht_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  tick_t in_tick,
    output logic  q_valid,
    input  logic  q_ready,
    output tick_t q_tick
);
    tick_t       mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_tick   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

/* sv/sht_engine.sv */
// Back part: bus phase sequencer driven one tick per beat.
module sht_engine import sht_pkg::*;
#(
    parameter int WAIT_WIDTH = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        t_valid,
    output logic        t_ready,
    input  tick_t       t_tick,
    input  logic        hold,
    input  logic [15:0] phase_ticks,
    input  logic [23:0] timeout_ticks,
    output logic        p_valid,
    output pins_t       p_pins,
    output conv_t       conv,
    output logic [7:0]  status_store
);
    localparam logic [WAIT_WIDTH-1:0] WAIT_MAX = '1;

    phase_t                phase_reg, phase_next, ph;
    logic [3:0]            bit_reg, bit_next;
    logic [15:0]           shift_reg, shift_next;
    logic [15:0]           tick_reg, tick_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [7:0]            cmd_reg, cmd_next;
    logic [7:0]            stat_reg, stat_next;
    logic [7:0]            chk_reg, chk_next;
    logic [3:0]            bc;
    logic [15:0]           sw;
    logic [7:0]            lc;
    logic                  bitv, over, step;
    logic                  done, nack, tmo, scl, rel;
    logic [WAIT_WIDTH:0]   limit;
    logic [2:0]            sidx;

    assign t_ready      = !hold;
    assign step         = t_valid && t_ready;
    assign status_store = stat_reg;

    // start of a request folded in
    always_comb
    begin
        ph = phase_reg;
        bc = bit_reg;
        sw = shift_reg;
        lc = cmd_reg;
        if (phase_reg == PH_IDLE && t_tick.action)
        begin
            ph = PH_START;
            bc = 4'd0;
            sw = {t_tick.status_data, t_tick.command_code};
            lc = t_tick.command_code;
        end
        bitv = sw[7];
        sidx = (bc > 4'd6) ? 3'(bc - 4'd7) : bc[2:0];
    end

    // pin outputs
    always_comb
    begin
        scl = 1'b0;
        rel = 1'b1;
        unique case (ph)
            PH_START:
            begin
                scl = START_SCL[sidx];
                rel = START_SDA[sidx];
            end
            PH_CB0, PH_WB0: rel = bitv;
            PH_CB1, PH_WB1:
            begin
                scl = 1'b1;
                rel = bitv;
            end
            PH_CB2, PH_WB2: rel = (bc == 4'd7) ? 1'b1 : bitv;
            PH_CA0, PH_WA0, PH_DB0, PH_KB0, PH_KE0: scl = 1'b1;
            PH_DB1: rel = (bc[2:0] != 3'd0);
            PH_DA0:
            begin
                scl = 1'b1;
                rel = 1'b0;
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = ph;
        bit_next   = bc;
        shift_next = sw;
        cmd_next   = lc;
        wait_next  = wait_reg;
        stat_next  = stat_reg;
        chk_next   = chk_reg;
        tick_next  = (phase_reg == PH_IDLE && t_tick.action) ? 16'd0 : tick_reg;
        done = 1'b0;
        nack = 1'b0;
        tmo  = 1'b0;
        over = 1'b0;
        conv = '0;
        conv.cmd = lc;
        conv.raw = sw;
        limit = ({8'd0, timeout_ticks} < {1'b0, WAIT_MAX}) ?
                (WAIT_WIDTH+1)'({8'd0, timeout_ticks}) : {1'b0, WAIT_MAX};
        if (ph == PH_WAIT)
        begin
            if ({1'b0, wait_reg} >= limit)
            begin
                tmo = 1'b1;
                phase_next = PH_IDLE;
            end
            else if (!t_tick.sda_in)
            begin
                phase_next = PH_MDLY;
                tick_next  = 16'd0;
            end
            else if (wait_reg != WAIT_MAX)
            begin
                wait_next = wait_reg + 1'b1;
            end
        end
        else if (ph != PH_IDLE)
        begin
            if (tick_next < phase_ticks)
            begin
                tick_next = tick_next + 16'd1;
            end
            else
            begin
                tick_next = 16'd0;
                over = 1'b1;
            end
        end
        if (over)
        begin
            unique case (ph)
                PH_START:
                    if (bc < 4'd6) bit_next = bc + 4'd1;
                    else
                    begin
                        bit_next   = 4'd0;
                        phase_next = PH_CB0;
                    end
                PH_CB0: phase_next = PH_CB1;
                PH_CB1: phase_next = PH_CB2;
                PH_CB2:
                begin
                    shift_next = {sw[15:8], sw[6:0], 1'b0};
                    bit_next   = bc + 4'd1;
                    if (bc + 4'd1 >= 4'd8)
                    begin
                        bit_next   = 4'd0;
                        phase_next = PH_CA0;
                    end
                    else phase_next = PH_CB0;
                end
                PH_CA0, PH_WA0:
                begin
                    shift_next = {sw[15:1], sw[0] | t_tick.sda_in};
                    phase_next = (ph == PH_CA0) ? PH_CA1 : PH_WA1;
                end
                PH_CA1:
                    priority if (sw[0])
                    begin
                        nack = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else if (lc == CMD_WRITE_STATUS)
                    begin
                        shift_next = {8'd0, sw[15:8]};
                        bit_next   = 4'd0;
                        phase_next = PH_WB0;
                    end
                    else if (lc == CMD_READ_STATUS)
                    begin
                        shift_next = 16'd0;
                        bit_next   = 4'd0;
                        phase_next = PH_DB0;
                    end
                    else
                    begin
                        wait_next  = '0;
                        phase_next = PH_WAIT;
                    end
                PH_WB0: phase_next = PH_WB1;
                PH_WB1: phase_next = PH_WB2;
                PH_WB2:
                begin
                    shift_next = {8'd0, sw[6:0], 1'b0};
                    bit_next   = bc + 4'd1;
                    if (bc + 4'd1 >= 4'd8)
                    begin
                        bit_next   = 4'd0;
                        phase_next = PH_WA0;
                    end
                    else phase_next = PH_WB0;
                end
                PH_WA1:
                begin
                    nack = sw[0];
                    done = !sw[0];
                    phase_next = PH_IDLE;
                end
                PH_MDLY:
                begin
                    shift_next = 16'd0;
                    bit_next   = 4'd0;
                    phase_next = PH_DB0;
                end
                PH_DB0:
                begin
                    shift_next = {sw[14:0], t_tick.sda_in};
                    bit_next   = bc + 4'd1;
                    phase_next = PH_DB1;
                end
                PH_DB1: phase_next = (bc[2:0] == 3'd0) ? PH_DA0 : PH_DB0;
                PH_DA0: phase_next = PH_DA1;
                PH_DA1:
                begin
                    if (lc == CMD_READ_STATUS) stat_next = sw[7:0];
                    if (lc == CMD_READ_STATUS || bc == 4'd0)
                    begin
                        bit_next   = 4'd0;
                        chk_next   = 8'd0;
                        phase_next = PH_KB0;
                    end
                    else phase_next = PH_DB0;
                end
                PH_KB0:
                begin
                    chk_next   = {chk_reg[6:0], t_tick.sda_in};
                    bit_next   = bc + 4'd1;
                    phase_next = PH_KB1;
                end
                PH_KB1: phase_next = (bc >= 4'd8) ? PH_KE0 : PH_KB0;
                PH_KE0: phase_next = PH_KE1;
                PH_KE1:
                begin
                    conv.go    = (lc != CMD_READ_STATUS);
                    done       = 1'b1;
                    bit_next   = 4'd0;
                    phase_next = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
            endcase
        end
        if (!step) conv.go = 1'b0;
        p_pins.scl  = scl;
        p_pins.rel  = rel;
        p_pins.busy = (phase_next != PH_IDLE);
        p_pins.done = done;
        p_pins.nack = nack;
        p_pins.tmo  = tmo;
        p_valid     = step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            wait_reg  <= '0;
            cmd_reg   <= '0;
            stat_reg  <= '0;
            chk_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            wait_reg  <= wait_next;
            cmd_reg   <= cmd_next;
            stat_reg  <= stat_next;
            chk_reg   <= chk_next;
        end
    end
endmodule

/* sv/sht_conv.sv */
// Conversion unit: temperature add and two-stage humidity polynomial.
module sht_conv import sht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  conv_t              conv,
    input  logic [13:0]        temp_offset,
    output logic               busy,
    output logic [15:0]        raw_value,
    output logic signed [16:0] temperature_centi,
    output logic signed [34:0] humidity_q20
);
    logic [1:0]         stg_reg;
    logic [15:0]        raw_reg;
    logic signed [16:0] temp_reg;
    logic signed [34:0] hum_reg;
    logic [31:0]        sq_reg;
    logic [33:0]        lin_reg;
    logic [43:0]        quad;

    assign busy              = (stg_reg != 2'd0);
    assign raw_value         = raw_reg;
    assign temperature_centi = temp_reg;
    assign humidity_q20      = hum_reg;
    assign quad              = 44'(HUM_QUAD) * {12'd0, sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_reg  <= 2'd0;
            raw_reg  <= '0;
            temp_reg <= '0;
            hum_reg  <= '0;
            sq_reg   <= '0;
            lin_reg  <= '0;
        end
        else
        begin
            if (conv.go)
            begin
                raw_reg <= conv.raw;
                if (conv.cmd == CMD_MEAS_TEMP)
                begin
                    temp_reg <= 17'({{3{temp_offset[13]}}, temp_offset})
                              + $signed({1'b0, conv.raw});
                end
                if (conv.cmd == CMD_MEAS_HUMI)
                begin
                    sq_reg  <= conv.raw * conv.raw;
                    lin_reg <= 34'(HUM_LIN) * {18'd0, conv.raw};
                    stg_reg <= 2'd1;
                end
            end
            else if (stg_reg == 2'd1)
            begin
                hum_reg <= 35'(HUM_BIAS) + $signed({1'b0, lin_reg})
                         - $signed({1'b0, quad[43:10]});
                stg_reg <= 2'd0;
            end
        end
    end
endmodule

/* sv/sht1x_two_wire_master.sv */
// Top level of the SHT1x two-wire sensor bus master.
// Each accepted input beat is one bus timer tick and yields exactly one result beat,
// one beat per cycle sustained while the output is not stalled and the conversion
// unit is not busy. Ticks pass through a two-entry queue into the bus sequencer,
// whose result lands in an output register; after a humidity measurement the
// conversion unit holds the sequencer and the result beat. Config writes are taken
// at any time and should be issued only while the block is idle.
module sht1x_two_wire_master import sht_pkg::*;
#(
    parameter int WAIT_WIDTH = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [7:0]         command_code,
    input  logic [7:0]         status_data,
    input  logic               sda_in,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               scl_out,
    output logic               sda_release,
    output logic               busy_res,
    output logic               done_res,
    output logic               nack_error,
    output logic               timeout_error,
    output logic [7:0]         status_value,
    output logic [15:0]        raw_value,
    output logic signed [16:0] temperature_centi,
    output logic signed [34:0] humidity_q20
);
    logic [15:0] phase_ticks_reg;
    logic [23:0] timeout_reg;
    logic [13:0] offset_reg;
    tick_t       in_tick, q_tick;
    logic        q_valid, q_ready, p_valid, conv_busy, hold, ov_reg;
    pins_t       pins, pins_reg;
    conv_t       conv;
    logic [7:0]  stat;

    assign in_tick   = '{action, command_code, status_data, sda_in};
    assign cfg_ready = 1'b1;
    assign hold      = conv_busy || (ov_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            timeout_reg     <= TIMEOUT_RST;
            offset_reg      <= TEMP_OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PHASE_TICKS:   phase_ticks_reg <= cfg_data[15:0];
                CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data;
                CFG_TEMP_OFFSET:   offset_reg      <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    sht_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_tick,
        .q_valid, .q_ready, .q_tick
    );

    sht_engine #(.WAIT_WIDTH(WAIT_WIDTH)) u_engine (
        .clk, .rst_n,
        .t_valid(q_valid), .t_ready(q_ready), .t_tick(q_tick), .hold,
        .phase_ticks(phase_ticks_reg), .timeout_ticks(timeout_reg),
        .p_valid, .p_pins(pins), .conv, .status_store(stat)
    );

    sht_conv u_conv (
        .clk, .rst_n, .conv, .temp_offset(offset_reg), .busy(conv_busy),
        .raw_value, .temperature_centi, .humidity_q20
    );

    // hold the result beat until taken; values come from the held stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            pins_reg <= '0;
        end
        else if (p_valid)
        begin
            ov_reg   <= 1'b1;
            pins_reg <= pins;
        end
        else if (out_valid && out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    assign out_valid     = ov_reg && !conv_busy;
    assign scl_out       = pins_reg.scl;
    assign sda_release   = pins_reg.rel;
    assign busy_res      = pins_reg.busy;
    assign done_res      = pins_reg.done;
    assign nack_error    = pins_reg.nack;
    assign timeout_error = pins_reg.tmo;
    assign status_value  = stat;
endmodule

/* sv/sht_checker.sv */
// Port checker for the SHT1x master, bound to the top level.
module sht_checker
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic busy_res,
    input logic done_res,
    input logic nack_error,
    input logic timeout_error
);
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({done_res, nack_error, timeout_error}) <= 1)
        else $error("more than one end event in a beat");

    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (done_res || nack_error || timeout_error) |-> !busy_res)
        else $error("sequence end with busy set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(busy_res))
        else $error("result beat dropped while stalled");
endmodule

bind sht1x_two_wire_master sht_checker u_sht_checker (
    .clk, .rst_n, .out_valid, .out_ready, .busy_res, .done_res,
    .nack_error, .timeout_error
);

/* sim/sht1x_two_wire_master_tb.sv */
// Testbench for the SHT1x two-wire bus master: tick stimulus, bus sequence predictor, result check.
`timescale 1ns / 100ps

module sht1x_two_wire_master_tb;
    import sht_pkg::*;

    typedef struct {
        phase_t      ph;
        logic [3:0]  bc;
        logic [15:0] sw;
        logic [15:0] tc;
        logic [23:0] wc;
        logic [7:0]  lc;
        logic [7:0]  st;
        logic [7:0]  ck;
        logic [15:0] raw;
        logic [16:0] temp;
        logic [34:0] hum;
    } bus_state_t;

    typedef struct packed {
        logic        scl;
        logic        rel;
        logic        busy;
        logic        done;
        logic        nack;
        logic        tmo;
        logic [7:0]  st;
        logic [15:0] raw;
        logic [16:0] temp;
        logic [34:0] hum;
    } bus_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic action = 1'b0;
    logic [7:0] command_code = '0;
    logic [7:0] status_data = '0;
    logic sda_in = 1'b1;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic scl_out, sda_release, busy_res, done_res, nack_error, timeout_error;
    logic [7:0] status_value;
    logic [15:0] raw_value;
    logic signed [16:0] temperature_centi;
    logic signed [34:0] humidity_q20;

    logic [15:0] phase_ticks = PHASE_TICKS_RST;
    logic [23:0] timeout_ticks = TIMEOUT_RST;
    logic [13:0] temp_offset = TEMP_OFFSET_RST;

    bus_state_t  plan_st, bus_st;
    tick_t       tick_q[$];
    bus_result_t bus_result_q[$];
    int          in_gap = 0;
    int          out_stall = 0;
    int          tick_total = 0;
    int          fail_count = 0;

    sht1x_two_wire_master dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .command_code(command_code),
        .status_data(status_data), .sda_in(sda_in),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .scl_out(scl_out), .sda_release(sda_release), .busy_res(busy_res),
        .done_res(done_res), .nack_error(nack_error), .timeout_error(timeout_error),
        .status_value(status_value), .raw_value(raw_value),
        .temperature_centi(temperature_centi), .humidity_q20(humidity_q20)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_state(output bus_state_t s);
        s.ph = PH_IDLE; s.bc = '0; s.sw = '0; s.tc = '0; s.wc = '0;
        s.lc = '0; s.st = '0; s.ck = '0; s.raw = '0; s.temp = '0; s.hum = '0;
    endfunction

    function automatic bus_result_t bus_tick(inout bus_state_t s, input tick_t t);
        bus_result_t r;
        logic        b;
        longint      d;
        r = '0;
        r.rel = 1'b1;
        b = s.sw[7];
        if (s.ph == PH_IDLE && t.action)
        begin
            s.ph = PH_START; s.bc = '0; s.tc = '0;
            s.lc = t.command_code; s.sw = {t.status_data, t.command_code};
            b = s.sw[7];
        end
        case (s.ph)
            PH_START: begin r.scl = START_SCL[s.bc]; r.rel = START_SDA[s.bc]; end
            PH_CB0, PH_WB0: r.rel = b;
            PH_CB1, PH_WB1: begin r.scl = 1'b1; r.rel = b; end
            PH_CB2, PH_WB2: r.rel = (s.bc == 4'd7) ? 1'b1 : b;
            PH_CA0, PH_WA0, PH_DB0, PH_KB0, PH_KE0: r.scl = 1'b1;
            PH_DB1: r.rel = (s.bc[2:0] != 3'd0);
            PH_DA0: begin r.scl = 1'b1; r.rel = 1'b0; end
            default: ;
        endcase
        if (s.ph == PH_WAIT)
        begin
            if (s.wc >= timeout_ticks)
            begin
                r.tmo = 1'b1; s.ph = PH_IDLE;
            end
            else if (!t.sda_in)
            begin
                s.ph = PH_MDLY; s.tc = '0;
            end
            else if (s.wc != '1)
                s.wc++;
        end
        else if (s.ph != PH_IDLE && s.tc < phase_ticks)
            s.tc++;
        else if (s.ph != PH_IDLE)
        begin
            s.tc = '0;
            case (s.ph)
                PH_START:
                    if (s.bc < 4'd6) s.bc++;
                    else begin s.bc = '0; s.ph = PH_CB0; end
                PH_CB0: s.ph = PH_CB1;
                PH_CB1: s.ph = PH_CB2;
                PH_CB2:
                begin
                    s.sw = {s.sw[15:8], s.sw[6:0], 1'b0};
                    s.bc++;
                    if (s.bc >= 4'd8) begin s.bc = '0; s.ph = PH_CA0; end
                    else s.ph = PH_CB0;
                end
                PH_CA0: begin s.sw[0] = s.sw[0] | t.sda_in; s.ph = PH_CA1; end
                PH_CA1:
                    if (s.sw[0]) begin r.nack = 1'b1; s.ph = PH_IDLE; end
                    else if (s.lc == CMD_WRITE_STATUS)
                    begin
                        s.sw = s.sw >> 8; s.bc = '0; s.ph = PH_WB0;
                    end
                    else if (s.lc == CMD_READ_STATUS)
                    begin
                        s.sw = '0; s.bc = '0; s.ph = PH_DB0;
                    end
                    else begin s.wc = '0; s.ph = PH_WAIT; end
                PH_WB0: s.ph = PH_WB1;
                PH_WB1: s.ph = PH_WB2;
                PH_WB2:
                begin
                    s.sw = {8'h00, s.sw[6:0], 1'b0};
                    s.bc++;
                    if (s.bc >= 4'd8) begin s.bc = '0; s.ph = PH_WA0; end
                    else s.ph = PH_WB0;
                end
                PH_WA0: begin s.sw[0] = s.sw[0] | t.sda_in; s.ph = PH_WA1; end
                PH_WA1:
                begin
                    if (s.sw[0]) r.nack = 1'b1;
                    else r.done = 1'b1;
                    s.ph = PH_IDLE;
                end
                PH_MDLY: begin s.sw = '0; s.bc = '0; s.ph = PH_DB0; end
                PH_DB0:
                begin
                    s.sw = {s.sw[14:0], t.sda_in};
                    s.bc = s.bc + 4'd1;
                    s.ph = PH_DB1;
                end
                PH_DB1: s.ph = (s.bc[2:0] == 3'd0) ? PH_DA0 : PH_DB0;
                PH_DA0: s.ph = PH_DA1;
                PH_DA1:
                begin
                    if (s.lc == CMD_READ_STATUS) s.st = s.sw[7:0];
                    if (s.lc == CMD_READ_STATUS || s.bc == 4'd0)
                    begin
                        s.bc = '0; s.ck = '0; s.ph = PH_KB0;
                    end
                    else s.ph = PH_DB0;
                end
                PH_KB0:
                begin
                    s.ck = {s.ck[6:0], t.sda_in};
                    s.bc++;
                    s.ph = PH_KB1;
                end
                PH_KB1: s.ph = (s.bc >= 4'd8) ? PH_KE0 : PH_KB0;
                PH_KE0: s.ph = PH_KE1;
                PH_KE1:
                begin
                    if (s.lc != CMD_READ_STATUS)
                    begin
                        d = longint'(s.sw);
                        s.raw = s.sw;
                        if (s.lc == CMD_MEAS_TEMP)
                            s.temp = 17'(longint'($signed(temp_offset)) + d);
                        else if (s.lc == CMD_MEAS_HUMI)
                            s.hum = 35'(-64'sd4194304 + 64'sd42467 * d
                                        - ((64'sd3006 * d * d) >>> 10));
                    end
                    r.done = 1'b1; s.bc = '0; s.ph = PH_IDLE;
                end
                default: s.ph = PH_IDLE;
            endcase
        end
        r.busy = (s.ph != PH_IDLE);
        r.st = s.st;
        r.raw = s.raw;
        r.temp = s.temp;
        r.hum = s.hum;
        return r;
    endfunction

    task automatic queue_tick(input tick_t t);
        bus_result_t unused;
        tick_q.push_back(t);
        unused = bus_tick(plan_st, t);
        tick_total++;
    endtask

    task automatic queue_noise(input int n);
        tick_t t;
        repeat (n)
        begin
            t = tick_t'($urandom);
            t.action = 1'b0;
            queue_tick(t);
        end
    endtask

    // wait_delay < 0: data line never goes low; data_mode 1 all ones, 2 all zeros
    task automatic queue_command(input logic [7:0] cmd, input logic [7:0] sd,
                                 input logic cmd_nack, input logic wr_nack,
                                 input int wait_delay, input int data_mode);
        tick_t t;
        int    waited;
        waited = 0;
        t.action = 1'b1;
        t.command_code = cmd;
        t.status_data = sd;
        t.sda_in = $urandom_range(1);
        queue_tick(t);
        while (plan_st.ph != PH_IDLE)
        begin
            t = tick_t'($urandom);
            t.action = ($urandom_range(9) == 0);
            case (plan_st.ph)
                PH_CA0, PH_CA1: t.sda_in = cmd_nack;
                PH_WA0, PH_WA1: t.sda_in = wr_nack;
                PH_WAIT:
                begin
                    t.sda_in = !(wait_delay >= 0 && waited >= wait_delay);
                    waited++;
                end
                default:
                    if (data_mode == 1) t.sda_in = 1'b1;
                    else if (data_mode == 2) t.sda_in = 1'b0;
            endcase
            queue_tick(t);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PHASE_TICKS:   phase_ticks = value[15:0];
            CFG_TIMEOUT_TICKS: timeout_ticks = value;
            default:           temp_offset = value[13:0];
        endcase
    endtask

    task automatic drain();
        while (tick_q.size() != 0 || in_valid || bus_result_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(5))
            0: return CMD_MEAS_TEMP;
            1: return CMD_MEAS_HUMI;
            2: return CMD_WRITE_STATUS;
            3: return CMD_READ_STATUS;
            default: return 8'($urandom);
        endcase
    endfunction

    // driver: predict each accepted beat, then present the next one
    always @(posedge clk)
    begin
        tick_t t;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                bus_result_q.push_back(bus_tick(bus_st,
                                                '{action, command_code, status_data, sda_in}));
            if (!in_valid || in_ready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= in_gap)
                begin
                    t = tick_q.pop_front();
                    action <= t.action;
                    command_code <= t.command_code;
                    status_data <= t.status_data;
                    sda_in <= t.sda_in;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        bus_result_t e;
        if (rst_n)
        begin
            out_ready <= ($urandom_range(99) >= out_stall);
            if (out_valid && out_ready)
            begin
                if (bus_result_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    e = bus_result_q.pop_front();
                    check_field("scl_out", e.scl, scl_out);
                    check_field("sda_release", e.rel, sda_release);
                    check_field("busy_res", e.busy, busy_res);
                    check_field("done_res", e.done, done_res);
                    check_field("nack_error", e.nack, nack_error);
                    check_field("timeout_error", e.tmo, timeout_error);
                    check_field("status_value", e.st, status_value);
                    check_field("raw_value", e.raw, raw_value);
                    check_field("temperature_centi", $signed(e.temp), temperature_centi);
                    check_field("humidity_q20", $signed(e.hum), humidity_q20);
                end
            end
        end
    end

    initial
    begin
        int to;
        clear_state(plan_st);
        clear_state(bus_st);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_PHASE_TICKS, 24'd0);
        write_reg(CFG_TIMEOUT_TICKS, 24'd20);
        write_reg(CFG_TEMP_OFFSET, 24'(-4100));
        queue_command(CMD_MEAS_TEMP, 8'h00, 1'b0, 1'b0, 3, 2);
        queue_command(CMD_MEAS_HUMI, 8'hFF, 1'b0, 1'b0, 0, 1);
        queue_command(CMD_MEAS_HUMI, 8'h00, 1'b0, 1'b0, 5, 0);
        queue_command(CMD_WRITE_STATUS, 8'hFF, 1'b0, 1'b0, 0, 0);
        queue_command(CMD_WRITE_STATUS, 8'h00, 1'b0, 1'b1, 0, 0);
        queue_command(CMD_READ_STATUS, 8'h5A, 1'b0, 1'b0, 0, 1);
        queue_command(8'hFF, 8'h00, 1'b1, 1'b0, 0, 0);
        queue_command(8'h00, 8'h00, 1'b0, 1'b0, -1, 0);
        queue_command(CMD_MEAS_TEMP, 8'hA5, 1'b0, 1'b0, 19, 1);
        queue_noise(4);
        drain();
        write_reg(CFG_TIMEOUT_TICKS, 24'd0);
        write_reg(CFG_PHASE_TICKS, 24'hFF0002);
        queue_command(CMD_MEAS_TEMP, 8'h00, 1'b0, 1'b0, 0, 0);
        drain();
        write_reg(CFG_TIMEOUT_TICKS, 24'hFFFFFF);
        write_reg(CFG_TEMP_OFFSET, 24'hFFC000);
        queue_command(CMD_MEAS_HUMI, 8'h00, 1'b0, 1'b0, 6, 0);
        queue_command(CMD_MEAS_TEMP, 8'h00, 1'b0, 1'b0, 2, 1);
        drain();

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin in_gap = 0;  out_stall = 0;  end
                1: begin in_gap = 66; out_stall = 0;  end
                2: begin in_gap = 0;  out_stall = 66; end
                default: begin in_gap = 10; out_stall = 10; end
            endcase
            write_reg(CFG_PHASE_TICKS, {8'($urandom), 16'($urandom_range(3))});
            write_reg(CFG_TIMEOUT_TICKS, 24'($urandom_range(60, 1)));
            write_reg(CFG_TEMP_OFFSET,
                      {10'($urandom), 14'(-$signed($urandom_range(4100)))});
            to = timeout_ticks;
            tick_total = 0;
            while (tick_total < 200)
            begin
                if ($urandom_range(3) == 0)
                    queue_noise($urandom_range(5, 1));
                else
                    queue_command(pick_command(), 8'($urandom),
                                  $urandom_range(9) == 0, $urandom_range(9) == 0,
                                  ($urandom_range(5) == 0) ? -1 : $urandom_range(to + 3),
                                  ($urandom_range(7) == 0) ? $urandom_range(2, 1) : 0);
            end
            drain();
        end

        in_gap = 0;
        out_stall = 0;
        write_reg(CFG_PHASE_TICKS, 24'h00FFFF);
        queue_noise(100);
        drain();

        if (fail_count == 0)
            $display("sht1x_two_wire_master test passed");
        else
            $display("sht1x_two_wire_master test failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("sht1x_two_wire_master test failed");
        $finish;
    end

endmodule
